// File: hdl/a64rel_pkg.sv
package a64rel_pkg;

	// Result sequence sizing
	localparam int MaxWords = 5;
	localparam int CntW     = $clog2(MaxWords + 1);

	// Fixed instruction words of the replacement sequences
	localparam logic [31:0] WORD_LDR_X16   = 32'h5800_0050;
	localparam logic [31:0] WORD_BR_X16    = 32'hD61F_0200;
	localparam logic [31:0] WORD_BLR_X16   = 32'hD63F_0200;
	localparam logic [31:0] WORD_MOVZ_X    = 32'hD280_0000;
	localparam logic [31:0] WORD_MOVK_X    = 32'hF280_0000;
	localparam logic [31:0] WORD_LDR_W_IND = 32'hB940_0000;
	localparam logic [31:0] WORD_LDR_X_IND = 32'hF940_0000;
	localparam logic [31:0] WORD_LDRSW_IND = 32'hB980_0000;

	// Decode masks and match values
	localparam logic [31:0] MASK_B      = 32'h7C00_0000;
	localparam logic [31:0] MATCH_B     = 32'h1400_0000;
	localparam logic [31:0] MASK_BCOND  = 32'hFF00_0010;
	localparam logic [31:0] MATCH_BCOND = 32'h5400_0000;
	localparam logic [31:0] MASK_CB     = 32'h7E00_0000;
	localparam logic [31:0] MATCH_CB    = 32'h3400_0000;
	localparam logic [31:0] MATCH_TB    = 32'h3600_0000;
	localparam logic [31:0] MASK_ADR    = 32'h9F00_0000;
	localparam logic [31:0] MATCH_ADRP  = 32'h9000_0000;
	localparam logic [31:0] MATCH_ADR   = 32'h1000_0000;
	localparam logic [7:0]  TOP_LDR_W   = 8'h18;
	localparam logic [7:0]  TOP_LDR_X   = 8'h58;
	localparam logic [7:0]  TOP_LDRSW   = 8'h98;

	// Skip displacement of the inverted branch: +20 bytes, imm field at bit 5
	localparam logic [31:0] SKIP_IMM = 32'h0000_00A0;

	// Literal load size codes (opc field)
	localparam logic [1:0] OPC_LDR_W = 2'd0;
	localparam logic [1:0] OPC_LDR_X = 2'd1;

	typedef enum logic [2:0] {
		KIND_BRANCH,
		KIND_BCOND,
		KIND_CBZ,
		KIND_TBZ,
		KIND_ADRP,
		KIND_ADR,
		KIND_LDRLIT,
		KIND_COPY
	} a64rel_kind_t;

	// One instruction's replacement: words in order, plus how many are used
	typedef struct packed {
		logic [MaxWords-1:0][31:0] words;
		logic [CntW-1:0]           cnt;
	} a64rel_seq_t;

endpackage

// File: hdl/a64rel_expand.sv
module a64rel_expand (
	input  logic [31:0]          instr_word,
	input  logic [63:0]          instr_addr,
	output a64rel_pkg::a64rel_seq_t seq
);
	import a64rel_pkg::*;

	a64rel_kind_t kind;
	logic [63:0]  base;
	logic [63:0]  offset;
	logic [63:0]  target;
	logic [4:0]   rt;
	logic [20:0]  adr_raw;

	assign rt      = instr_word[4:0];
	assign adr_raw = {instr_word[23:5], instr_word[30:29]};

	// Instruction class, in priority order
	always_comb begin
		if ((instr_word & MASK_B) == MATCH_B) begin
			kind = KIND_BRANCH;
		end else if ((instr_word & MASK_BCOND) == MATCH_BCOND) begin
			kind = KIND_BCOND;
		end else if ((instr_word & MASK_CB) == MATCH_CB) begin
			kind = KIND_CBZ;
		end else if ((instr_word & MASK_CB) == MATCH_TB) begin
			kind = KIND_TBZ;
		end else if ((instr_word & MASK_ADR) == MATCH_ADRP) begin
			kind = KIND_ADRP;
		end else if ((instr_word & MASK_ADR) == MATCH_ADR) begin
			kind = KIND_ADR;
		end else if (instr_word[31:24] == TOP_LDR_W || instr_word[31:24] == TOP_LDR_X
				|| instr_word[31:24] == TOP_LDRSW) begin
			kind = KIND_LDRLIT;
		end else begin
			kind = KIND_COPY;
		end
	end

	// Sign-extended displacement and base for the single target adder
	always_comb begin
		base = instr_addr;
		case (kind)
			KIND_BRANCH: offset = {{36{instr_word[25]}}, instr_word[25:0], 2'b00};
			KIND_TBZ:    offset = {{48{instr_word[18]}}, instr_word[18:5], 2'b00};
			KIND_ADRP: begin
				base   = {instr_addr[63:12], 12'h000};
				offset = {{31{instr_word[23]}}, adr_raw, 12'h000};
			end
			KIND_ADR:    offset = {{43{instr_word[23]}}, adr_raw};
			default:     offset = {{43{instr_word[23]}}, instr_word[23:5], 2'b00};
		endcase
	end

	assign target = base + offset;

	// Word list for each class
	always_comb begin
		logic [CntW-1:0] n;
		logic [31:0]     front;
		n     = '0;
		front = WORD_LDRSW_IND;
		seq.words = '0;
		seq.cnt   = '0;
		case (kind)
			KIND_BRANCH: begin
				seq.words[0] = WORD_LDR_X16;
				seq.words[1] = instr_word[31] ? WORD_BLR_X16 : WORD_BR_X16;
				seq.words[2] = target[31:0];
				seq.words[3] = target[63:32];
				seq.cnt      = CntW'(4);
			end
			KIND_BCOND, KIND_CBZ, KIND_TBZ: begin
				// inverted branch that skips the absolute jump
				if (kind == KIND_BCOND) begin
					seq.words[0] = MATCH_BCOND | SKIP_IMM
						| {28'h0, instr_word[3:1], ~instr_word[0]};
				end else if (kind == KIND_CBZ) begin
					seq.words[0] = MATCH_CB | SKIP_IMM | {instr_word[31], 31'h0}
						| {7'h0, ~instr_word[24], 24'h0} | {27'h0, rt};
				end else begin
					seq.words[0] = MATCH_TB | SKIP_IMM | {instr_word[31], 31'h0}
						| {7'h0, ~instr_word[24], 24'h0}
						| {8'h0, instr_word[23:19], 19'h0} | {27'h0, rt};
				end
				seq.words[1] = WORD_LDR_X16;
				seq.words[2] = WORD_BR_X16;
				seq.words[3] = target[31:0];
				seq.words[4] = target[63:32];
				seq.cnt      = CntW'(5);
			end
			KIND_ADRP, KIND_ADR, KIND_LDRLIT: begin
				// movz, then movk for nonzero upper half-words; bits 47:32 also if 63:48 are nonzero
				seq.words[0] = WORD_MOVZ_X | {11'h0, target[15:0], rt};
				n = CntW'(1);
				if (target[31:16] != 16'h0) begin
					seq.words[n] = WORD_MOVK_X | {9'h0, 2'd1, target[31:16], rt};
					n = n + CntW'(1);
				end
				if (target[63:32] != 32'h0) begin
					seq.words[n] = WORD_MOVK_X | {9'h0, 2'd2, target[47:32], rt};
					n = n + CntW'(1);
				end
				if (target[63:48] != 16'h0) begin
					seq.words[n] = WORD_MOVK_X | {9'h0, 2'd3, target[63:48], rt};
					n = n + CntW'(1);
				end
				if (kind == KIND_LDRLIT) begin
					if (instr_word[31:30] == OPC_LDR_W) begin
						front = WORD_LDR_W_IND;
					end else if (instr_word[31:30] == OPC_LDR_X) begin
						front = WORD_LDR_X_IND;
					end else begin
						front = WORD_LDRSW_IND;
					end
					seq.words[n] = front | {22'h0, rt, rt};
					n = n + CntW'(1);
				end
				seq.cnt = n;
			end
			default: begin
				seq.words[0] = instr_word;
				seq.cnt      = CntW'(1);
			end
		endcase
	end

endmodule

// File: hdl/a64rel_outbuf.sv
module a64rel_outbuf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  a64rel_pkg::a64rel_seq_t seq,
	output logic                    drain_last,
	output logic                    result_valid,
	output logic [31:0]             out_word,
	output logic                    last_word
);
	import a64rel_pkg::*;

	logic [MaxWords-1:0][31:0] words_s2;
	logic [CntW-1:0]           cnt_s2;

	// Remaining word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= seq.cnt;
		end else if (cnt_s2 != '0) begin
			cnt_s2 <= cnt_s2 - CntW'(1);
		end
	end

	// Word shift line: head word goes out each cycle
	always_ff @(posedge clk) begin
		if (load) begin
			words_s2 <= seq.words;
		end else begin
			for (int i = 0; i < MaxWords - 1; i++) begin
				words_s2[i] <= words_s2[i+1];
			end
		end
	end

	// Buffer is free for a new item after this cycle
	assign drain_last   = (cnt_s2 <= CntW'(1));
	assign result_valid = (cnt_s2 != '0);
	assign out_word     = words_s2[0];
	assign last_word    = (cnt_s2 == CntW'(1));

endmodule

// File: hdl/arm64_pc_relative_relocator_core.sv
// ARM64 PC-relative instruction relocator.
// Input: pulse start with instr_word and instr_addr while busy is low; the
// item is taken at that clock edge. busy is high while an item waits for the
// output buffer.
// Output: the replacement words leave one per cycle on out_word, each marked
// by result_valid for one cycle; last_word flags the final word of an item.
// The receiver cannot stall; words are simply presented in order.
// Timing: with the buffer free, the first word of an item is on out_word
// from the clock edge after it is taken.
// Throughput: an item occupies the output buffer while its words (1 to 5)
// are presented; the next item is decoded while the last word of the
// previous one is out, so words stream without gaps while the sender keeps
// up. The one-word result port sets the rate.
// Reset (arst_n low) empties the input register and the output buffer; no
// words are presented until a new item is taken.
module arm64_pc_relative_relocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instr_word,
	input  logic [63:0] instr_addr,
	output logic        result_valid,
	output logic [31:0] out_word,
	output logic        last_word
);
	import a64rel_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [63:0] addr_s1;
	logic        accept;
	logic        load;
	logic        drain_last;
	a64rel_seq_t seq;

	// Decoded item moves to the buffer once the buffer is empty or on its last word
	assign load   = valid_s1 && drain_last;
	assign busy   = valid_s1 && !drain_last;
	assign accept = start && !busy;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= instr_word;
			addr_s1 <= instr_addr;
		end
	end

	a64rel_expand u_expand (
		.instr_word (word_s1),
		.instr_addr (addr_s1),
		.seq        (seq)
	);

	a64rel_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.seq          (seq),
		.drain_last   (drain_last),
		.result_valid (result_valid),
		.out_word     (out_word),
		.last_word    (last_word)
	);

endmodule

// File: test/relocated_word_checker.sv
`timescale 1ns / 1ps

// Watches the instruction and word channels of the relocator, works out the
// replacement sequence for every accepted instruction and compares each word
// that leaves the block with the oldest word still owed.
module relocated_word_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] instr_word,
	input  logic [63:0] instr_addr,
	input  logic        result_valid,
	input  logic [31:0] out_word,
	input  logic        last_word,
	output int          failures,
	output int          outstanding,
	output int          items_taken,
	output int          words_checked,
	output logic [7:0]  kinds_seen
);
	import a64rel_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} owed_word_t;

	// Words still owed by the block, oldest first
	owed_word_t  owed_words[$];
	// Replacement of the instruction being predicted
	logic [31:0] seq_words[$];

	int         fail_cnt  = 0;
	int         owed_cnt  = 0;
	int         item_cnt  = 0;
	int         word_cnt  = 0;
	logic [7:0] kind_mask = '0;

	assign failures      = fail_cnt;
	assign outstanding   = owed_cnt;
	assign items_taken   = item_cnt;
	assign words_checked = word_cnt;
	assign kinds_seen    = kind_mask;

	task automatic stage(input logic [31:0] w);
		seq_words.push_back(w);
	endtask

	// ldr x16 literal, br/blr x16, then the 64-bit target low half first
	task automatic stage_jump(input logic [31:0] second, input logic [63:0] target);
		stage(WORD_LDR_X16);
		stage(second);
		stage(target[31:0]);
		stage(target[63:32]);
	endtask

	// movz for the low half-word, movk for nonzero upper half-words, bits 47:32 also if 63:48 are nonzero
	task automatic stage_const(input logic [4:0] rd, input logic [63:0] v);
		stage(WORD_MOVZ_X | {11'd0, v[15:0], rd});
		if (v[31:16] != 16'd0)
			stage(WORD_MOVK_X | {9'd0, 2'd1, v[31:16], rd});
		if (v[63:32] != 32'd0)
			stage(WORD_MOVK_X | {9'd0, 2'd2, v[47:32], rd});
		if (v[63:48] != 16'd0)
			stage(WORD_MOVK_X | {9'd0, 2'd3, v[63:48], rd});
	endtask

	// Decode one instruction and queue the words its replacement is made of
	task automatic relocate_instr(input logic [31:0] w, input logic [63:0] pc);
		logic [4:0]   rt;
		logic [63:0]  target;
		logic [31:0]  front;
		a64rel_kind_t kind;
		rt = w[4:0];
		seq_words.delete();
		if ((w & MASK_B) == MATCH_B) begin
			kind   = KIND_BRANCH;
			target = pc + {{36{w[25]}}, w[25:0], 2'b00};
			stage_jump(w[31] ? WORD_BLR_X16 : WORD_BR_X16, target);
		end else if ((w & MASK_BCOND) == MATCH_BCOND) begin
			// condition low bit flips even for AL/NV
			kind   = KIND_BCOND;
			target = pc + {{43{w[23]}}, w[23:5], 2'b00};
			stage(MATCH_BCOND | SKIP_IMM | {28'd0, w[3:0] ^ 4'd1});
			stage_jump(WORD_BR_X16, target);
		end else if ((w & MASK_CB) == MATCH_CB) begin
			// inverted compare keeps its width bit
			kind   = KIND_CBZ;
			target = pc + {{43{w[23]}}, w[23:5], 2'b00};
			stage({w[31], 31'd0} | MATCH_CB | {7'd0, ~w[24], 24'd0} | SKIP_IMM
				| {27'd0, rt});
			stage_jump(WORD_BR_X16, target);
		end else if ((w & MASK_CB) == MATCH_TB) begin
			// inverted test keeps b5 and b40
			kind   = KIND_TBZ;
			target = pc + {{48{w[18]}}, w[18:5], 2'b00};
			stage({w[31], 31'd0} | MATCH_TB | {7'd0, ~w[24], 24'd0}
				| {8'd0, w[23:19], 19'd0} | SKIP_IMM | {27'd0, rt});
			stage_jump(WORD_BR_X16, target);
		end else if ((w & MASK_ADR) == MATCH_ADRP) begin
			kind   = KIND_ADRP;
			target = {pc[63:12], 12'd0} + {{31{w[23]}}, w[23:5], w[30:29], 12'd0};
			stage_const(rt, target);
		end else if ((w & MASK_ADR) == MATCH_ADR) begin
			kind   = KIND_ADR;
			target = pc + {{43{w[23]}}, w[23:5], w[30:29]};
			stage_const(rt, target);
		end else if (w[31:24] == TOP_LDR_W || w[31:24] == TOP_LDR_X
				|| w[31:24] == TOP_LDRSW) begin
			// literal offset always in words, load goes through Rt itself
			kind   = KIND_LDRLIT;
			target = pc + {{43{w[23]}}, w[23:5], 2'b00};
			if (w[31:30] == OPC_LDR_W)
				front = WORD_LDR_W_IND;
			else if (w[31:30] == OPC_LDR_X)
				front = WORD_LDR_X_IND;
			else
				front = WORD_LDRSW_IND;
			stage_const(rt, target);
			stage(front | {22'd0, rt, rt});
		end else begin
			kind = KIND_COPY;
			stage(w);
		end
		kind_mask[kind] = 1'b1;
		foreach (seq_words[i])
			owed_words.push_back({seq_words[i], i == seq_words.size() - 1});
	endtask

	// Predict on every accepted item, check every word that leaves
	always @(posedge clk) begin : watch
		owed_word_t head;
		if (arst_n) begin
			if (start && !busy) begin
				relocate_instr(instr_word, instr_addr);
				item_cnt++;
			end
			if (result_valid) begin
				word_cnt++;
				if (owed_words.size() == 0) begin
					fail_cnt++;
					$display("%0t: word %h (last %b) with none expected",
						$time, out_word, last_word);
				end else begin
					head = owed_words.pop_front();
					if (out_word !== head.word) begin
						fail_cnt++;
						$display("%0t: out_word expected %h, got %h",
							$time, head.word, out_word);
					end
					if (last_word !== head.last) begin
						fail_cnt++;
						$display("%0t: last_word expected %b, got %b (word %h)",
							$time, head.last, last_word, head.word);
					end
				end
			end
			owed_cnt = owed_words.size();
		end
	end

endmodule

// File: test/arm64_pc_relative_relocator_core_test.sv
`timescale 1ns / 1ps

module arm64_pc_relative_relocator_core_test;
	import a64rel_pkg::*;

	localparam logic [7:0] TOP_PRFM = 8'hD8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] instr_word;
	logic [63:0] instr_addr;
	logic        result_valid;
	logic [31:0] out_word;
	logic        last_word;

	int         failures;
	int         outstanding;
	int         items_taken;
	int         words_checked;
	logic [7:0] kinds_seen;

	// Chance in a hundred that the sender holds off for a cycle
	int idle_pct = 0;

	arm64_pc_relative_relocator_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.instr_word   (instr_word),
		.instr_addr   (instr_addr),
		.result_valid (result_valid),
		.out_word     (out_word),
		.last_word    (last_word)
	);

	relocated_word_checker word_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.instr_word    (instr_word),
		.instr_addr    (instr_addr),
		.result_valid  (result_valid),
		.out_word      (out_word),
		.last_word     (last_word),
		.failures      (failures),
		.outstanding   (outstanding),
		.items_taken   (items_taken),
		.words_checked (words_checked),
		.kinds_seen    (kinds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(input logic [31:0] w, input logic [63:0] a);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		instr_word <= w;
		instr_addr <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly well-formed PC-relative encodings with random fields, some noise
	function automatic logic [31:0] random_instr();
		logic [31:0]  r;
		logic [31:0]  w;
		a64rel_kind_t pick;
		r    = $urandom;
		pick = a64rel_kind_t'(3'($urandom_range(7)));
		if ($urandom_range(9) == 0)
			return r;
		case (pick)
			KIND_BRANCH: w = (r & ~MASK_B) | MATCH_B;
			KIND_BCOND: begin
				w    = (r & ~MASK_BCOND) | MATCH_BCOND;
				w[4] = ($urandom_range(7) == 0);
			end
			KIND_CBZ:    w = (r & ~MASK_CB) | MATCH_CB;
			KIND_TBZ:    w = (r & ~MASK_CB) | MATCH_TB;
			KIND_ADRP:   w = (r & ~MASK_ADR) | MATCH_ADRP;
			KIND_ADR:    w = (r & ~MASK_ADR) | MATCH_ADR;
			KIND_LDRLIT: begin
				case ($urandom_range(2))
					0:       w = {TOP_LDR_W, r[23:0]};
					1:       w = {TOP_LDR_X, r[23:0]};
					default: w = {TOP_LDRSW, r[23:0]};
				endcase
			end
			default:     w = {TOP_PRFM, r[23:0]};
		endcase
		return w;
	endfunction

	// Addresses spread so that every movz/movk length shows up
	function automatic logic [63:0] random_addr();
		case ($urandom_range(4))
			1:       return {32'd0, 32'($urandom)};
			2:       return {48'd0, 16'($urandom)};
			3:       return {40'hFF_FFFF_FFFF, 24'($urandom)};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Run limit
	initial begin
		#500_000;
		$display("arm64_pc_relative_relocator_core_test: errors");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		instr_word = '0;
		instr_addr = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes, each rewrite, wrap-around and copies
		send_item(32'h15FF_FFFF, 64'h0);                   // B, largest forward
		send_item(32'h1600_0000, 64'h0);                   // B, most negative, wraps
		send_item(32'h9400_0001, 64'hFFFF_FFFF_FFFF_FFFF); // BL, wraps past top
		send_item(32'h5400_0040, 64'h0000_0000_0040_0000); // B.EQ
		send_item(32'h54FF_FFEE, 64'h8000_0000_0000_0000); // B.AL, backward
		send_item(32'h5400_002F, 64'hFFFF_FFFF_FFFF_FFF0); // B.NV
		send_item(32'h5400_0010, 64'h1234);                // bit 4 set: copied
		send_item(32'h3400_0025, 64'h1000);                // CBZ w5
		send_item(32'hB5FF_FFFF, 64'h0);                   // CBNZ x31, negative
		send_item(32'hB6F8_001F, 64'hDEAD_BEEF_0000_0000); // TBZ b5 set, bit 63
		send_item(32'h3700_0000, 64'h0);                   // TBNZ bit 0
		send_item(32'h377F_FFE3, 64'hFFFF_FFFF_FFFF_FFFF); // TBNZ, one instruction back
		send_item(32'h1000_0000, 64'h0);                   // ADR to zero: movz only
		send_item(32'h70FF_FFE0, 64'h0);                   // ADR -1: all four parts
		send_item(32'h9000_0001, 64'h0000_0000_1234_5FFF); // ADRP, page base
		send_item(32'hF0FF_FFFF, 64'h0);                   // ADRP, one page back, x31
		send_item(32'h1800_0041, 64'h0000_0000_0000_1000); // LDR w literal
		send_item(32'h58FF_FFFF, 64'h0000_0000_0000_0000); // LDR x literal, x31, wraps
		send_item(32'h9880_0002, 64'hFFFF_0000_0000_0000); // LDRSW literal
		send_item(32'hD800_0020, 64'h4000);                // PRFM literal: copied
		send_item(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(32'hFFFF_FFFF, 64'h0);
		send_item(32'hD503_201F, 64'h5555_AAAA_5555_AAAA); // NOP

		// Random phases: back to back, sparse sender, moderately sparse sender
		idle_pct = 0;
		repeat (66)
			send_item(random_instr(), random_addr());
		idle_pct = 74;
		repeat (66)
			send_item(random_instr(), random_addr());
		idle_pct = 37;
		repeat (66)
			send_item(random_instr(), random_addr());
		start <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);

		$display("%0d instructions relocated, %0d words compared, %0d of 8 decode kinds hit",
			items_taken, words_checked, $countones(kinds_seen));
		$display("sender pacing: back to back, 74%% idle and 37%% idle");
		if (failures == 0)
			$display("arm64_pc_relative_relocator_core_test: clean");
		else
			$display("arm64_pc_relative_relocator_core_test: errors");
		$finish;
	end

endmodule
